### rtl/tmvs_pkg.sv
// ----------------------------------------------------------------------------
// tmvs_pkg
// shared types, constants and helpers of the visible tile window scanner
// ----------------------------------------------------------------------------
package tmvs_pkg;

	localparam int MAX_MAP_DIM  = 4096;
	localparam int MAX_TILE_DIM = 256;

	localparam int COORD_W = 12;  // tile column and row index
	localparam int TILE_W  = 9;   // tile size register
	localparam int DIM_W   = 13;  // map and window size registers
	localparam int ORG_W   = 16;  // camera origin
	localparam int POS_W   = 22;  // on-screen position
	localparam int QUO_W   = 16;  // divider dividend and quotient
	localparam int IDX_W   = 3;   // register index
	localparam int JOB_W   = 2;

	// register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_TILE_WIDTH    = 3'd0;
	localparam logic [IDX_W-1:0] REG_TILE_HEIGHT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAP_COLS      = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAP_ROWS      = 3'd3;
	localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_SCAN_ALL      = 3'd6;

	// input op codes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	// bound jobs run through the shared divider, in this order
	localparam logic [JOB_W-1:0] JOB_COL_LO = 2'd0;
	localparam logic [JOB_W-1:0] JOB_COL_HI = 2'd1;
	localparam logic [JOB_W-1:0] JOB_ROW_LO = 2'd2;
	localparam logic [JOB_W-1:0] JOB_ROW_HI = 2'd3;

	typedef struct packed {
		logic [TILE_W-1:0] tile_width;
		logic [TILE_W-1:0] tile_height;
		logic [DIM_W-1:0]  map_cols;
		logic [DIM_W-1:0]  map_rows;
		logic [DIM_W-1:0]  screen_width;
		logic [DIM_W-1:0]  screen_height;
		logic              scan_all;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic             load;    // start accepted: latch origin, drop any scan
		logic             div_go;  // launch divider on job
		logic             store;   // divider done: store clamped bound of job
		logic             commit;  // all bounds stored: arm the cursor
		logic             adv;     // advance accepted: emit one result
		logic [JOB_W-1:0] job;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_stall;
	} sts_t;

	// tile size as used: zero reads as one, clipped at the maximum
	function automatic logic [TILE_W-1:0] eff_tile(input logic [TILE_W-1:0] r);
		logic [TILE_W-1:0] v;
		if (r == '0)
			v = TILE_W'(1);
		else if (r > TILE_W'(MAX_TILE_DIM))
			v = TILE_W'(MAX_TILE_DIM);
		else
			v = r;
		return v;
	endfunction

	// map size as used, minus one: the highest valid index
	function automatic logic [COORD_W-1:0] eff_map_m1(input logic [DIM_W-1:0] r);
		logic [COORD_W-1:0] v;
		if (r == '0)
			v = '0;
		else if (r > DIM_W'(MAX_MAP_DIM))
			v = COORD_W'(MAX_MAP_DIM - 1);
		else
			v = COORD_W'(r - DIM_W'(1));
		return v;
	endfunction

	// window size as used, minus one
	function automatic logic [DIM_W-1:0] eff_span_m1(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		if (r == '0)
			v = '0;
		else
			v = r - DIM_W'(1);
		return v;
	endfunction

endpackage

### rtl/tmvs_div.sv
// ----------------------------------------------------------------------------
// tmvs_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module tmvs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [tmvs_pkg::QUO_W-1:0]   dividend,
	input  logic [tmvs_pkg::TILE_W-1:0]  divisor,
	output logic [tmvs_pkg::QUO_W-1:0]   quotient,
	output logic                         done
);
	import tmvs_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic [QUO_W-1:0]  quo_q;
	logic [TILE_W-1:0] rem_q;
	logic [TILE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TILE_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the divisor width
			rem_q <= fits ? TILE_W'(trial - {1'b0, dvs_q}) : TILE_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### rtl/tmvs_dp.sv
// ----------------------------------------------------------------------------
// tmvs_dp
// scan datapath: bound computation, tile cursor, position and output register
// ----------------------------------------------------------------------------
module tmvs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tmvs_pkg::cfg_t                    cfg,
	input  tmvs_pkg::cmd_t                    cmd,
	output tmvs_pkg::sts_t                    sts,
	input  logic signed [tmvs_pkg::ORG_W-1:0] origin_x,
	input  logic signed [tmvs_pkg::ORG_W-1:0] origin_y,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [71:0]                       m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);
	import tmvs_pkg::*;

	logic signed [ORG_W-1:0] held_x_q, held_y_q;
	logic [COORD_W-1:0] first_col_q, last_col_q, first_row_q, last_row_q;
	logic [COORD_W-1:0] cur_col_q, cur_row_q;
	logic               scanning_q;

	logic               ovalid_q;
	logic               ores_q;
	logic [COORD_W-1:0] ocol_q, orow_q;
	logic [POS_W-1:0]   osx_q, osy_q;
	logic               olast_q;

	logic [TILE_W-1:0]  tw, th;
	logic [COORD_W-1:0] cols_m1, rows_m1;
	logic signed [ORG_W:0] sum_x, sum_y;

	logic [QUO_W-1:0]   dvd;
	logic               dvd_neg;
	logic [TILE_W-1:0]  dvs;
	logic [QUO_W-1:0]   quo;
	logic               div_done;
	logic [COORD_W-1:0] lim;
	logic               hi_job;
	logic [COORD_W-1:0] bound;

	logic [20:0]        prod_x, prod_y;
	logic [POS_W-1:0]   sx, sy;
	logic               fin;

	assign tw      = eff_tile(cfg.tile_width);
	assign th      = eff_tile(cfg.tile_height);
	assign cols_m1 = eff_map_m1(cfg.map_cols);
	assign rows_m1 = eff_map_m1(cfg.map_rows);

	// far window edge: origin plus span minus one, never past 17 signed bits
	assign sum_x = {held_x_q[ORG_W-1], held_x_q}
		+ $signed({4'b0, eff_span_m1(cfg.screen_width)});
	assign sum_y = {held_y_q[ORG_W-1], held_y_q}
		+ $signed({4'b0, eff_span_m1(cfg.screen_height)});

	// a negative dividend truncates to zero or below, which clamps to zero
	always_comb begin
		case (cmd.job)
			JOB_COL_LO: begin
				dvd     = held_x_q;
				dvd_neg = held_x_q[ORG_W-1];
			end
			JOB_COL_HI: begin
				dvd     = sum_x[QUO_W-1:0];
				dvd_neg = sum_x[ORG_W];
			end
			JOB_ROW_LO: begin
				dvd     = held_y_q;
				dvd_neg = held_y_q[ORG_W-1];
			end
			JOB_ROW_HI: begin
				dvd     = sum_y[QUO_W-1:0];
				dvd_neg = sum_y[ORG_W];
			end
			default: begin
				dvd     = '0;
				dvd_neg = 1'b1;
			end
		endcase
	end

	assign dvs    = cmd.job[1] ? th : tw;
	assign lim    = cmd.job[1] ? rows_m1 : cols_m1;
	assign hi_job = cmd.job[0];

	tmvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		if (cfg.scan_all)
			bound = hi_job ? lim : '0;
		else if (dvd_neg)
			bound = '0;
		else if (quo > QUO_W'(lim))
			bound = lim;
		else
			bound = quo[COORD_W-1:0];
	end

	// screen position of the current tile
	assign prod_x = 21'(cur_col_q) * 21'(tw);
	assign prod_y = 21'(cur_row_q) * 21'(th);
	assign sx = POS_W'(prod_x) - POS_W'(held_x_q);
	assign sy = POS_W'(prod_y) - POS_W'(held_y_q);
	assign fin = (cur_col_q == last_col_q) && (cur_row_q == last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			first_col_q <= '0;
			last_col_q  <= '0;
			first_row_q <= '0;
			last_row_q  <= '0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			scanning_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				held_x_q   <= origin_x;
				held_y_q   <= origin_y;
				scanning_q <= 1'b0;
			end
			if (cmd.store) begin
				case (cmd.job)
					JOB_COL_LO: first_col_q <= bound;
					JOB_COL_HI: last_col_q  <= bound;
					JOB_ROW_LO: first_row_q <= bound;
					JOB_ROW_HI: last_row_q  <= bound;
					default:    first_col_q <= first_col_q;
				endcase
			end
			if (cmd.commit) begin
				cur_col_q  <= first_col_q;
				cur_row_q  <= first_row_q;
				scanning_q <= 1'b1;
			end
			if (cmd.adv && scanning_q) begin
				if (fin) begin
					scanning_q <= 1'b0;
				end else if (cur_col_q == last_col_q) begin
					cur_col_q <= first_col_q;
					cur_row_q <= cur_row_q + COORD_W'(1);
				end else begin
					cur_col_q <= cur_col_q + COORD_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.adv) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.adv) begin
			ores_q  <= scanning_q;
			ocol_q  <= scanning_q ? cur_col_q : '0;
			orow_q  <= scanning_q ? cur_row_q : '0;
			osx_q   <= scanning_q ? sx : '0;
			osy_q   <= scanning_q ? sy : '0;
			olast_q <= scanning_q && fin;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = ores_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {4'b0, osy_q, osx_q, orow_q, ocol_q};

	assign sts.div_done  = div_done;
	assign sts.out_stall = ovalid_q && !m_tready;

endmodule

### rtl/tmvs_ctrl.sv
// ----------------------------------------------------------------------------
// tmvs_ctrl
// scan controller: input handshake and sequencing of the four bound divisions
// ----------------------------------------------------------------------------
module tmvs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic           s_tuser,
	input  tmvs_pkg::sts_t sts,
	output tmvs_pkg::cmd_t cmd
);
	import tmvs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GO   = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]       state_q, state_d;
	logic [JOB_W-1:0] job_q, job_d;
	logic             acc;

	assign s_tready = (state_q == ST_IDLE) && !sts.out_stall;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		cmd        = '0;
		cmd.job    = job_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && s_tuser == OP_START) begin
					cmd.load = 1'b1;
					job_d    = JOB_COL_LO;
					state_d  = ST_GO;
				end else if (acc && s_tuser == OP_ADVANCE) begin
					cmd.adv = 1'b1;
				end
			end
			ST_GO: begin
				cmd.div_go = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					cmd.store = 1'b1;
					if (job_q == JOB_ROW_HI) begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						job_d   = job_q + JOB_W'(1);
						state_d = ST_GO;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_COL_LO;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

endmodule

### rtl/tile_map_visible_scan.sv
// ----------------------------------------------------------------------------
// tile_map_visible_scan
// walks the map tiles inside a camera window (all tiles with scan_all), one tile per advance
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: op; tdata: origin_x, origin_y
// m_*      out  m_tvalid/m_tready  tuser: valid_res; tlast: last;
//                                  tdata: tile_col, tile_row, screen_x, screen_y
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// an advance loads the output register; advances stream at one per cycle while
// m_tready is high, and the output register holds a result while m_tready is low
// a start runs four bound divisions in turn on one shared restoring divider,
// each with launch and store steps; s_tready is low meanwhile
// s_tready also drops while a result waits and m_tready is low
// reset clears the scan, the bounds and the cursor and loads the register defaults
//
module tile_map_visible_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // origin_x[15:0], origin_y[31:16]
	input  logic                          s_tuser,   // op
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [71:0]                   m_tdata,   // tile_col[11:0], tile_row[23:12],
	                                                 // screen_x[45:24], screen_y[67:46]
	output logic                          m_tuser,   // valid_res
	output logic                          m_tlast,   // last tile of the scan
	// register writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tmvs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [tmvs_pkg::DIM_W-1:0]    cfg_data
);
	import tmvs_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// register file, writes always taken; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_width    <= TILE_W'(16);
			cfg_q.tile_height   <= TILE_W'(16);
			cfg_q.map_cols      <= DIM_W'(64);
			cfg_q.map_rows      <= DIM_W'(64);
			cfg_q.screen_width  <= DIM_W'(320);
			cfg_q.screen_height <= DIM_W'(240);
			cfg_q.scan_all      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILE_WIDTH:    cfg_q.tile_width    <= cfg_data[TILE_W-1:0];
				REG_TILE_HEIGHT:   cfg_q.tile_height   <= cfg_data[TILE_W-1:0];
				REG_MAP_COLS:      cfg_q.map_cols      <= cfg_data;
				REG_MAP_ROWS:      cfg_q.map_rows      <= cfg_data;
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				REG_SCAN_ALL:      cfg_q.scan_all      <= cfg_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// controller owns the input handshake and the start sequence
	tmvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath holds bounds, cursor, divider and the output register
	tmvs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.origin_x (s_tdata[15:0]),
		.origin_y (s_tdata[31:16]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### rtl/tmvs_chk.sv
// ----------------------------------------------------------------------------
// tmvs_chk
// port-level checks of the visible tile window scanner
// ----------------------------------------------------------------------------
module tmvs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);
	import tmvs_pkg::*;

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// last only on a result that carries a tile
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last marked on an empty result");

	// an empty result carries all zeros
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0 && !m_tlast)
		else $error("empty result carries data");

	// a start transfer blocks input while the bounds are computed
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_START |=> !s_tready)
		else $error("input taken during bound computation");

	// an advance transfer gives a result in the next cycle
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_ADVANCE |=> m_tvalid)
		else $error("advance produced no result");

endmodule

bind tile_map_visible_scan tmvs_chk u_chk (.*);
